// ----- sv/serial_frame_deframer_defines.svh -----
// assertion macros used by the deframer parser
`ifndef SERIAL_FRAME_DEFRAMER_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_DEFINES_SVH

// property holds at every clock edge out of reset
`define SFD_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sfd_pkg.sv -----
package sfd_pkg;

  // frame layout
  localparam int unsigned MagicBytes = 4;
  localparam int unsigned HdrBytes   = 8;

  // reset value of the expected magic word
  localparam logic [31:0] MagicReset = 32'hFCFD_FEFF;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } result_kind_e;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_MAGIC   = 2'd1,
    STATUS_BAD_CSUM    = 2'd2,
    STATUS_LEN_TOO_BIG = 2'd3
  } frame_status_e;

  typedef struct packed {
    result_kind_e  result_kind;
    logic [7:0]    payload_byte;
    logic [6:0]    payload_index;
    frame_status_e frame_status;
  } result_t;

  // result of one byte step, with its valid
  typedef struct packed {
    logic    valid;
    result_t data;
  } step_res_t;

endpackage

// ----- sv/sfd_if.sv -----
// received byte channel
interface sfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface sfd_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] payload_byte;
  logic [6:0] payload_index;
  logic [1:0] frame_status;

  modport source (output valid, output result_kind, output payload_byte,
                  output payload_index, output frame_status, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input payload_index, input frame_status, output ready);
endinterface

// configuration write channel
interface sfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] expected_magic;

  modport source (output valid, output expected_magic, input ready);
  modport sink   (input valid, input expected_magic, output ready);
endinterface

// ----- sv/sfd_in_reg.sv -----
module sfd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfd_rx_if.sink     rx_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  // take a new byte when empty or when the held byte moves on
  assign rx_i.ready = !valid_q || advance_i;
  assign accept     = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // byte payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ----- sv/sfd_parser.sv -----
module sfd_parser import sfd_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 140,
  parameter int unsigned PAYLOAD_MAX = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfd_cfg_if.sink    cfg_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output step_res_t  step_res_o
);

  localparam logic [7:0]  MagicLastB = 8'(MagicBytes - 1);
  localparam logic [7:0]  HdrBytesB  = 8'(HdrBytes);
  localparam logic [7:0]  MagicEndB  = 8'(MagicBytes);
  localparam logic [7:0]  CsumPosB   = 8'(HdrBytes + PAYLOAD_MAX);
  localparam logic [7:0]  LastPosB   = 8'(FRAME_BYTES - 1);
  localparam logic [31:0] PayloadMaxW = 32'(PAYLOAD_MAX);

  logic [31:0] expected_magic_q;
  logic [7:0]  pos_q, pos_d;
  logic [31:0] magic_q, magic_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  xor_q, xor_d;
  logic        magic_good_q, magic_good_d;
  logic        csum_good_q, csum_good_d;

  logic [31:0] magic_next;
  logic [7:0]  idx;
  logic        idx_in_len;
  logic        is_last;
  step_res_t   res;

  // configuration register, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_magic_q <= MagicReset;
    end else if (cfg_i.valid) begin
      expected_magic_q <= cfg_i.expected_magic;
    end
  end

  // byte decode
  assign magic_next = {byte_i, magic_q[31:8]};
  assign idx        = pos_q - HdrBytesB;
  assign idx_in_len = {24'd0, idx} < len_q;
  assign is_last    = pos_q >= LastPosB;

  // frame state update and result forming
  always_comb begin
    pos_d        = pos_q;
    magic_d      = magic_q;
    len_d        = len_q;
    xor_d        = xor_q;
    magic_good_d = magic_good_q;
    csum_good_d  = csum_good_q;
    res          = '0;

    if (step_i) begin
      priority if (pos_q < MagicEndB) begin
        magic_d = magic_next;
        if (pos_q == MagicLastB) begin
          magic_good_d = (magic_next == expected_magic_q);
        end
      end else if (pos_q < HdrBytesB) begin
        len_d = {byte_i, len_q[31:8]};
      end else if (pos_q < CsumPosB) begin
        if (idx_in_len) begin
          xor_d = xor_q ^ byte_i;
          if (magic_good_q) begin
            res.valid              = 1'b1;
            res.data.result_kind   = KIND_PAYLOAD;
            res.data.payload_byte  = byte_i;
            res.data.payload_index = idx[6:0];
            res.data.frame_status  = STATUS_OK;
          end
        end
      end else if (pos_q == CsumPosB) begin
        csum_good_d = (byte_i == xor_q);
      end else begin
        pos_d = pos_q;
      end

      if (is_last) begin
        res.valid              = 1'b1;
        res.data.result_kind   = KIND_STATUS;
        res.data.payload_byte  = '0;
        res.data.payload_index = '0;
        priority if (!magic_good_q) begin
          res.data.frame_status = STATUS_BAD_MAGIC;
        end else if (len_q > PayloadMaxW) begin
          res.data.frame_status = STATUS_LEN_TOO_BIG;
        end else if (!csum_good_d) begin
          res.data.frame_status = STATUS_BAD_CSUM;
        end else begin
          res.data.frame_status = STATUS_OK;
        end
        pos_d        = '0;
        magic_d      = '0;
        len_d        = '0;
        xor_d        = '0;
        magic_good_d = 1'b0;
        csum_good_d  = 1'b0;
      end else begin
        pos_d = pos_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      magic_q      <= '0;
      len_q        <= '0;
      xor_q        <= '0;
      magic_good_q <= 1'b0;
      csum_good_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      magic_q      <= magic_d;
      len_q        <= len_d;
      xor_q        <= xor_d;
      magic_good_q <= magic_good_d;
      csum_good_q  <= csum_good_d;
    end
  end

  assign step_res_o = res;

  `include "serial_frame_deframer_defines.svh"

  // frame position stays inside the frame
  `SFD_ASSERT(a_pos_range, clk_i, rst_ni, pos_q <= LastPosB, "frame position past last byte")
  // a status result starts a new frame
  `SFD_ASSERT_NEXT(a_frame_restart, clk_i, rst_ni, step_i && is_last, pos_q == 8'd0 && !magic_good_q, "frame not restarted after status")
  // payload results only pass with a good magic
  `SFD_ASSERT(a_payload_magic, clk_i, rst_ni, !(res.valid && res.data.result_kind == KIND_PAYLOAD) || magic_good_q, "payload result with bad magic")

endmodule

// ----- sv/sfd_out_reg.sv -----
module sfd_out_reg import sfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  step_res_t step_res_i,
  output logic      space_o,
  sfd_res_if.source res_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // free when empty or when the held result is taken this cycle
  assign space_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (step_res_i.valid) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (step_res_i.valid) begin
      data_q <= step_res_i.data;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.result_kind   = data_q.result_kind;
  assign res_o.payload_byte  = data_q.payload_byte;
  assign res_o.payload_index = data_q.payload_index;
  assign res_o.frame_status  = data_q.frame_status;

endmodule

// ----- sv/serial_frame_deframer.sv -----
// Fixed-length frame deframer: one received byte per transfer on rx_i.
// Each frame is FRAME_BYTES bytes: a 4-byte little-endian magic word, a
// 4-byte little-endian payload length, payload bytes from offset 8, and
// an XOR checksum byte at offset 8 + PAYLOAD_MAX. With a good magic each
// payload byte below the length is sent on res_o with its index; the
// last byte of every frame sends one status result (ok, bad magic, bad
// checksum, length too large). cfg_i writes the expected magic word; write
// it only while no bytes are in flight.
// Each byte is decoded from the input register, and any result waits in
// the result register. Throughput: one byte per cycle while res_o is not
// stalled, set by the single decode step between the two registers.
// Reset: expected magic returns to 0xFCFDFEFF, the frame position to zero,
// and both registers empty.
// When the receiver stalls res_o, the held result waits and decoding stops;
// an empty input register still takes one byte, then rx_i.ready stays low
// until res_o moves.
module serial_frame_deframer import sfd_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 140,
  parameter int unsigned PAYLOAD_MAX = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfd_rx_if.sink    rx_i,
  sfd_cfg_if.sink   cfg_i,
  sfd_res_if.source res_o
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_space;
  logic       step;
  step_res_t  step_res;

  // decode runs when a byte waits and the result register has room
  assign step = in_valid && out_space;

  sfd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_i),
    .advance_i (step),
    .valid_o   (in_valid),
    .byte_o    (in_byte)
  );

  sfd_parser #(
    .FRAME_BYTES (FRAME_BYTES),
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .step_i     (step),
    .byte_i     (in_byte),
    .step_res_o (step_res)
  );

  sfd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_res_i (step_res),
    .space_o    (out_space),
    .res_o      (res_o)
  );

endmodule
